/* rtl/sptp_pkg.sv */
// Shared types and constants for the servo PWM timer with compare preload.
`default_nettype none

package sptp_pkg;

    localparam int CHANNEL_COUNT_DEF = 3;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int PULSE_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int PIN_COUNT    = 3;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PRESCALE = 3'd0,
        REG_RELOAD   = 3'd1,
        REG_FLOOR    = 3'd2,
        REG_CEILING  = 3'd3,
        REG_NEUTRAL  = 3'd4,
        REG_IDLE     = 3'd5
    } reg_index_t;

    localparam logic [PULSE_BITS-1:0] PRESCALE_RESET = 16'd83;
    localparam logic [PULSE_BITS-1:0] RELOAD_RESET   = 16'd19999;
    localparam logic [PULSE_BITS-1:0] FLOOR_RESET    = 16'd1000;
    localparam logic [PULSE_BITS-1:0] CEILING_RESET  = 16'd2000;
    localparam logic [PULSE_BITS-1:0] NEUTRAL_RESET  = 16'd1500;
    localparam logic [PULSE_BITS-1:0] IDLE_RESET     = 16'd1000;

endpackage

`default_nettype wire

/* rtl/servo_pwm_timer_preload_unit.sv */
// Servo PWM timer: prescaler, frame counter, preloaded compares and result buffer.
// Latency: a result is valid in the cycle after its request transaction while the
// output register is free, else it waits in the skid. Throughput: one request
// per cycle while the skid is empty; the counter step, clamp and compare logic
// all settle between the request edge and the result register. A two-entry result
// buffer (output register plus skid) takes one more request while the result side
// stalls. Reset clears buffer and counters and restores registers and compares.
`default_nettype none

module servo_pwm_timer_preload_unit #(
    parameter int CHANNEL_COUNT = sptp_pkg::CHANNEL_COUNT_DEF,
    parameter int COUNT_BITS    = sptp_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sptp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [sptp_pkg::PULSE_BITS-1:0]      cfg_data,
    input  wire logic                                 req_valid,
    output logic                                      req_ready,
    input  wire logic [1:0]                           req_type,
    input  wire logic [1:0]                           channel,
    input  wire logic [sptp_pkg::PULSE_BITS-1:0]      pulse_in,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output logic [sptp_pkg::PIN_COUNT-1:0]            pin_levels,
    output logic [sptp_pkg::PULSE_BITS-1:0]           read_value,
    output logic                                      update_event
);

    import sptp_pkg::*;

    localparam int CMP_BITS = (COUNT_BITS > PULSE_BITS) ? COUNT_BITS : PULSE_BITS;

    typedef struct packed {
        logic [PIN_COUNT-1:0]  pins;
        logic [PULSE_BITS-1:0] rdata;
        logic                  upd;
    } result_t;

    logic [PULSE_BITS-1:0] prescale_div_reg;
    logic [PULSE_BITS-1:0] reload_value_reg;
    logic [PULSE_BITS-1:0] pulse_floor_reg;
    logic [PULSE_BITS-1:0] pulse_ceiling_reg;

    logic [PULSE_BITS-1:0] prescale_count_reg, prescale_count_next;
    logic [COUNT_BITS-1:0] frame_count_reg, frame_count_next;
    logic [PULSE_BITS-1:0] preload_reg [CHANNEL_COUNT];
    logic [PULSE_BITS-1:0] preload_next [CHANNEL_COUNT];
    logic [PULSE_BITS-1:0] active_reg [CHANNEL_COUNT];
    logic [PULSE_BITS-1:0] active_next [CHANNEL_COUNT];

    result_t out_reg, skid_reg, result_next;
    logic    out_valid_reg, skid_valid_reg;

    logic                  req_accept;
    logic                  out_fire;
    logic                  update_next;
    logic [PULSE_BITS-1:0] clamped;
    logic [PULSE_BITS-1:0] rdata_next;
    logic [PIN_COUNT-1:0]  pins_next;
    logic [CMP_BITS-1:0]   frame_ext;

    assign cfg_ready  = 1'b1;
    assign req_ready  = !skid_valid_reg;
    assign req_accept = req_valid && req_ready;
    assign out_fire   = out_valid_reg && res_ready;

    // Configuration registers; the reset compare values only matter at reset,
    // so writes to their indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_div_reg  <= PRESCALE_RESET;
            reload_value_reg  <= RELOAD_RESET;
            pulse_floor_reg   <= FLOOR_RESET;
            pulse_ceiling_reg <= CEILING_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PRESCALE: prescale_div_reg  <= cfg_data;
                REG_RELOAD:   reload_value_reg  <= cfg_data;
                REG_FLOOR:    pulse_floor_reg   <= cfg_data;
                REG_CEILING:  pulse_ceiling_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        if (pulse_in < pulse_floor_reg)
            clamped = pulse_floor_reg;
        else if (pulse_in > pulse_ceiling_reg)
            clamped = pulse_ceiling_reg;
        else
            clamped = pulse_in;
    end

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        frame_count_next    = frame_count_reg;
        update_next         = 1'b0;
        rdata_next          = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            preload_next[c] = preload_reg[c];
            active_next[c]  = active_reg[c];
        end

        case (req_type)
            REQ_TICK:
            begin
                if (prescale_count_reg < prescale_div_reg)
                    prescale_count_next = prescale_count_reg + 1'b1;
                else
                begin
                    prescale_count_next = '0;
                    if (CMP_BITS'(frame_count_reg) < CMP_BITS'(reload_value_reg))
                        frame_count_next = frame_count_reg + 1'b1;
                    else
                    begin
                        frame_count_next = '0;
                        update_next      = 1'b1;
                        for (int c = 0; c < CHANNEL_COUNT; c++)
                            active_next[c] = preload_reg[c];
                    end
                end
            end
            REQ_WRITE:
            begin
                for (int c = 0; c < CHANNEL_COUNT; c++)
                    if (channel == 2'(c))
                        preload_next[c] = clamped;
            end
            REQ_READ:
            begin
                for (int c = 0; c < CHANNEL_COUNT; c++)
                    if (channel == 2'(c))
                        rdata_next = preload_reg[c];
            end
            default: ;
        endcase
    end

    assign frame_ext = CMP_BITS'(frame_count_next);

    // Pin levels reflect the state after the request has been applied.
    for (genvar p = 0; p < PIN_COUNT; p++)
    begin : g_pin
        if (p < CHANNEL_COUNT)
        begin : g_used
            assign pins_next[p] = frame_ext < CMP_BITS'(active_next[p]);
        end
        else
        begin : g_unused
            assign pins_next[p] = 1'b0;
        end
    end

    assign result_next = '{pins: pins_next, rdata: rdata_next, upd: update_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            frame_count_reg    <= '0;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                preload_reg[c] <= (c < 2) ? NEUTRAL_RESET : IDLE_RESET;
                active_reg[c]  <= (c < 2) ? NEUTRAL_RESET : IDLE_RESET;
            end
        end
        else if (req_accept)
        begin
            prescale_count_reg <= prescale_count_next;
            frame_count_reg    <= frame_count_next;
            for (int c = 0; c < CHANNEL_COUNT; c++)
            begin
                preload_reg[c] <= preload_next[c];
                active_reg[c]  <= active_next[c];
            end
        end
    end

    // Result buffer: the skid entry catches a transaction taken while the
    // output register is stalled, and drains into it on the next hand-off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= req_accept;
        end
        else if (req_accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (req_accept)
                out_reg <= result_next;
        end
        else if (req_accept)
            skid_reg <= result_next;
    end

    assign res_valid    = out_valid_reg;
    assign pin_levels   = out_reg.pins;
    assign read_value   = out_reg.rdata;
    assign update_event = out_reg.upd;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_update_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && update_next) |=> (frame_count_reg == '0 && prescale_count_reg == '0))
        else $error("update event did not restart the counters");

    a_non_tick_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req_type != REQ_TICK) |=>
            ($stable(frame_count_reg) && $stable(prescale_count_reg)))
        else $error("counters moved on a request that is not a tick");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && res_ready) |=> !skid_valid_reg)
        else $error("skid entry did not drain after a result hand-off");
`endif

endmodule

`default_nettype wire

/* tb/servo_pwm_timer_preload_checker.sv */
`timescale 1ns / 1ps
// Checker for the servo PWM timer: predicts each response from the observed requests and compares.
module servo_pwm_timer_preload_checker
    import sptp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PULSE_BITS-1:0]   cfg_data,
    input  logic                    req_valid,
    input  logic                    req_ready,
    input  logic [1:0]              req_type,
    input  logic [1:0]              channel,
    input  logic [PULSE_BITS-1:0]   pulse_in,
    input  logic                    res_valid,
    input  logic                    res_ready,
    input  logic [PIN_COUNT-1:0]    pin_levels,
    input  logic [PULSE_BITS-1:0]   read_value,
    input  logic                    update_event,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic [PIN_COUNT-1:0]  pins;
        logic [PULSE_BITS-1:0] readback;
        logic                  wrapped;
    } timer_result_t;

    logic [PULSE_BITS-1:0]       prescale_div;
    logic [PULSE_BITS-1:0]       reload_value;
    logic [PULSE_BITS-1:0]       pulse_floor;
    logic [PULSE_BITS-1:0]       pulse_ceiling;
    logic [PULSE_BITS-1:0]       prescale_count;
    logic [COUNT_BITS_DEF-1:0]   frame_count;
    logic [PULSE_BITS-1:0]       compare_preload [CHANNEL_COUNT_DEF];
    logic [PULSE_BITS-1:0]       compare_active [CHANNEL_COUNT_DEF];
    timer_result_t               pwm_results_due [$];
    int                          fail_total;

    // Applies one request to the timer state and returns the response it produces.
    function automatic timer_result_t advance_timer(input req_type_t kind,
                                                    input logic [1:0] ch,
                                                    input logic [PULSE_BITS-1:0] pulse);
        timer_result_t r;
        r = '0;
        case (kind)
            REQ_TICK:
            begin
                if (prescale_count < prescale_div)
                begin
                    prescale_count = prescale_count + 1'b1;
                end
                else
                begin
                    // A count already at or past a lowered limit wraps on the next step.
                    prescale_count = '0;
                    if (frame_count < reload_value)
                    begin
                        frame_count = frame_count + 1'b1;
                    end
                    else
                    begin
                        frame_count = '0;
                        for (int c = 0; c < CHANNEL_COUNT_DEF; c++)
                        begin
                            compare_active[c] = compare_preload[c];
                        end
                        r.wrapped = 1'b1;
                    end
                end
            end
            REQ_WRITE:
            begin
                // With an inverted band, pulses below the floor get the floor and all others the ceiling.
                if (ch < CHANNEL_COUNT_DEF)
                begin
                    compare_preload[ch] = (pulse < pulse_floor)   ? pulse_floor   :
                                          (pulse > pulse_ceiling) ? pulse_ceiling : pulse;
                end
            end
            REQ_READ:
            begin
                if (ch < CHANNEL_COUNT_DEF)
                begin
                    r.readback = compare_preload[ch];
                end
            end
            default:
            begin
            end
        endcase
        for (int c = 0; c < PIN_COUNT; c++)
        begin
            r.pins[c] = (frame_count < compare_active[c]);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t got;
        timer_result_t want;
        if (!rst_n)
        begin
            prescale_div       = PRESCALE_RESET;
            reload_value       = RELOAD_RESET;
            pulse_floor        = FLOOR_RESET;
            pulse_ceiling      = CEILING_RESET;
            prescale_count     = '0;
            frame_count        = '0;
            compare_preload[0] = NEUTRAL_RESET;
            compare_preload[1] = NEUTRAL_RESET;
            compare_preload[2] = IDLE_RESET;
            compare_active[0]  = NEUTRAL_RESET;
            compare_active[1]  = NEUTRAL_RESET;
            compare_active[2]  = IDLE_RESET;
            pwm_results_due.delete();
            fail_total = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PRESCALE: prescale_div  = cfg_data;
                    REG_RELOAD:   reload_value  = cfg_data;
                    REG_FLOOR:    pulse_floor   = cfg_data;
                    REG_CEILING:  pulse_ceiling = cfg_data;
                    // Neutral and idle values only matter at reset, which also restores them.
                    default:
                    begin
                    end
                endcase
            end
            if (res_valid && res_ready)
            begin
                got = {pin_levels, read_value, update_event};
                if (pwm_results_due.size() == 0)
                begin
                    if (fail_total < 10)
                    begin
                        $display("%0t: response with nothing outstanding: pins %0h read %0h update %0b",
                                 $realtime, got.pins, got.readback, got.wrapped);
                    end
                    fail_total++;
                end
                else
                begin
                    want = pwm_results_due.pop_front();
                    if (got.pins !== want.pins || got.readback !== want.readback ||
                        got.wrapped !== want.wrapped)
                    begin
                        if (fail_total < 10)
                        begin
                            $display("%0t: response mismatch: pins exp %0h got %0h, read exp %0h got %0h, update exp %0b got %0b",
                                     $realtime, want.pins, got.pins, want.readback, got.readback,
                                     want.wrapped, got.wrapped);
                        end
                        fail_total++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                pwm_results_due.push_back(advance_timer(req_type_t'(req_type), channel, pulse_in));
            end
            errors  <= fail_total;
            pending <= pwm_results_due.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the servo PWM timer: drives requests and register writes and gives the verdict.
module tb;
    import sptp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 108;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
    logic [PULSE_BITS-1:0]   cfg_data     = '0;
    logic                    req_valid    = 1'b0;
    logic                    req_ready;
    logic [1:0]              req_type     = '0;
    logic [1:0]              channel      = '0;
    logic [PULSE_BITS-1:0]   pulse_in     = '0;
    logic                    res_valid;
    logic                    res_ready    = 1'b0;
    logic [PIN_COUNT-1:0]    pin_levels;
    logic [PULSE_BITS-1:0]   read_value;
    logic                    update_event;

    int errors;
    int pending;
    int quiet_cycles;
    bit burst;
    bit hold_request;

    always #2 clk = ~clk;

    servo_pwm_timer_preload_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .channel      (channel),
        .pulse_in     (pulse_in),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .pin_levels   (pin_levels),
        .read_value   (read_value),
        .update_event (update_event)
    );

    servo_pwm_timer_preload_checker timer_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .channel      (channel),
        .pulse_in     (pulse_in),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .pin_levels   (pin_levels),
        .read_value   (read_value),
        .update_event (update_event),
        .errors       (errors),
        .pending      (pending)
    );

    // Valid is never dropped between back-to-back transactions, only before a gap.
    task automatic send_item(input req_type_t kind, input logic [1:0] ch,
                             input logic [PULSE_BITS-1:0] pulse);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        channel   <= ch;
        pulse_in  <= pulse;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [PULSE_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    // Response side: short random stalls, runs with no stall, and one long hold on request.
    initial
    begin
        int rx_stall;
        int rx_free_run;
        int long_hold;
        rx_stall    = 0;
        rx_free_run = 0;
        long_hold   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                long_hold    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (res_valid && res_ready)
            begin
                if (rx_free_run > 0)
                begin
                    rx_free_run--;
                    rx_stall = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    rx_free_run = 30;
                    rx_stall    = 0;
                end
                else
                begin
                    rx_stall = $urandom_range(0, 5);
                end
            end
            if (long_hold > 0)
            begin
                long_hold--;
                res_ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int phase;
        int k;
        int pick;
        req_type_t kind;
        logic [1:0] ch;
        logic [PULSE_BITS-1:0] pulse;
        logic [PULSE_BITS-1:0] p_div, p_top, p_lo, p_hi;

        burst        = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: neutral and idle compares, the unknown channel, clamping at both ends.
        for (k = 0; k < 4; k++)
        begin
            send_item(REQ_READ, 2'(k), 16'($urandom));
        end
        send_item(REQ_NONE, 2'd1, 16'hFFFF);
        send_item(REQ_WRITE, 2'd0, 16'h0000);
        send_item(REQ_WRITE, 2'd1, 16'hFFFF);
        send_item(REQ_WRITE, 2'd2, 16'd1700);
        send_item(REQ_WRITE, 2'd3, 16'd1234);
        for (k = 0; k < 4; k++)
        begin
            send_item(REQ_READ, 2'(k), 16'($urandom));
        end
        send_item(REQ_TICK, 2'd0, 16'd0);
        send_item(REQ_TICK, 2'd2, 16'hFFFF);

        // A short frame so the update event and compare load are seen early.
        wait_idle();
        write_reg(REG_PRESCALE, 16'd0);
        write_reg(REG_RELOAD, 16'd2);
        cfg_valid <= 1'b0;
        for (k = 0; k < 4; k++)
        begin
            send_item(REQ_TICK, 2'(k), 16'd0);
        end
        send_item(REQ_READ, 2'd2, 16'd0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0: {p_div, p_top, p_lo, p_hi} = {16'd0, 16'd0, 16'd0, 16'hFFFF};
                1: {p_div, p_top, p_lo, p_hi} = {16'd0, 16'hFFFF, 16'd5, 16'd30};
                2: {p_div, p_top, p_lo, p_hi} = {16'hFFFF, 16'd5, 16'd0, 16'd40};
                3: {p_div, p_top, p_lo, p_hi} = {16'd0, 16'd300, 16'd0, 16'd200};
                // The frame counter is now far above the new top, and the band is inverted.
                4: {p_div, p_top, p_lo, p_hi} = {16'd0, 16'd3, 16'd10, 16'd2};
                5: {p_div, p_top, p_lo, p_hi} = {16'd1, 16'd20, 16'hFFFF, 16'd0};
                9: {p_div, p_top, p_lo, p_hi} = {16'($urandom_range(0, 2)), 16'($urandom_range(0, 30)),
                                                 16'($urandom), 16'($urandom)};
                default:
                begin
                    p_div = 16'($urandom_range(0, 3));
                    p_top = 16'($urandom_range(0, 40));
                    p_lo  = 16'($urandom_range(0, 25));
                    p_hi  = 16'($urandom_range(5, 50));
                end
            endcase
            write_reg(REG_PRESCALE, p_div);
            write_reg(REG_RELOAD, p_top);
            write_reg(REG_FLOOR, p_lo);
            write_reg(REG_CEILING, p_hi);
            if (phase % 3 == 1)
            begin
                write_reg(REG_NEUTRAL, 16'($urandom));
                write_reg(REG_IDLE, 16'($urandom));
            end
            if (phase == 7)
            begin
                write_reg(REG_UNMAPPED_LO, 16'($urandom));
                write_reg(REG_UNMAPPED_HI, 16'($urandom));
            end
            cfg_valid <= 1'b0;

            burst = (phase == 4) || ($urandom_range(0, 3) == 0);
            if (phase == 4)
            begin
                hold_request = 1'b1;
            end

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 6 && k == PHASE_ITEMS / 2)
                begin
                    wait_idle();
                end
                pick  = $urandom_range(0, 99);
                kind  = (pick < 50) ? REQ_TICK : (pick < 75) ? REQ_WRITE :
                        (pick < 95) ? REQ_READ : REQ_NONE;
                ch    = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                pulse = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 60));
                send_item(kind, ch, pulse);
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
